// File: rtl/rbsr_pkg.sv
// ----------------------------------------------------------------------------
// rbsr_pkg
// Shared widths, opcode type and span record of the ring buffer span
// reservation block.
// ----------------------------------------------------------------------------
package rbsr_pkg;

    localparam int MAX_BYTES = 4096;
    localparam int PTR_W     = $clog2(MAX_BYTES);
    localparam int CNT_W     = PTR_W + 1;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        logic [PTR_W-1:0] offset;
        logic [CNT_W-1:0] first;
        logic [PTR_W-1:0] second;
        logic [CNT_W-1:0] grant;
        logic             complete;
        logic [PTR_W-1:0] next_ptr;
        logic [CNT_W-1:0] next_fill;
    } span_t;

endpackage

// File: rtl/rbsr_span_calc.sv
// ----------------------------------------------------------------------------
// rbsr_span_calc
// Span arithmetic for one request: contiguous and wrapped regions, grant,
// advanced pointer and fill level after the step.
// ----------------------------------------------------------------------------
module rbsr_span_calc (
    input  rbsr_pkg::op_t                 op,
    input  logic [rbsr_pkg::CNT_W-1:0]    req,
    input  logic [rbsr_pkg::CNT_W-1:0]    cap,
    input  logic [rbsr_pkg::PTR_W-1:0]    rd_ptr,
    input  logic [rbsr_pkg::PTR_W-1:0]    wr_ptr,
    input  logic [rbsr_pkg::CNT_W-1:0]    fill,
    output rbsr_pkg::span_t               span
);
    import rbsr_pkg::*;

    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] other;
    logic             blocked;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] grant;
    logic [CNT_W-1:0] sum;
    logic [CNT_W-1:0] wrapped;

    always_comb
    begin
        cur   = (op == OP_WRITE) ? wr_ptr : rd_ptr;
        other = (op == OP_WRITE) ? rd_ptr : wr_ptr;
        // a writer is blocked by a full store, a reader by an empty one
        blocked = (op == OP_WRITE) ? (fill == cap) : (fill == '0);
        avail   = (op == OP_WRITE) ? (cap - fill) : fill;
        grant   = (req < avail) ? req : avail;

        span.offset = cur;
        if (cur < other)
        begin
            span.first  = {1'b0, other} - {1'b0, cur};
            span.second = '0;
        end
        else if (blocked)
        begin
            span.first  = '0;
            span.second = '0;
        end
        else
        begin
            span.first  = cap - {1'b0, cur};
            span.second = other;
        end

        // pointer is below cap and grant at most cap: one subtract wraps it
        sum     = {1'b0, cur} + grant;
        wrapped = (sum >= cap) ? (sum - cap) : sum;

        span.grant     = grant;
        span.complete  = (grant == req);
        span.next_ptr  = wrapped[PTR_W-1:0];
        span.next_fill = (op == OP_WRITE) ? (fill + grant) : (fill - grant);
    end

endmodule

// File: rtl/ring_buffer_span_reservation.sv
// ----------------------------------------------------------------------------
// ring_buffer_span_reservation
// Pointer manager of a byte ring store: reserves write or read spans.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy stays low, so one
// request per clock is sustained. Each request gives exactly one result,
// marked by a one-cycle done strobe, in request order: it is held in the
// request register, then passes through the span arithmetic into the result
// register. The receiver cannot stall; results must be taken when
// done is high. The pointer and fill state are updated in the arithmetic
// stage, so back-to-back requests see each other's effect. A capacity
// write clamps the value to 1..4096 and empties the buffer; issue it only
// when no request is in flight.
module ring_buffer_span_reservation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rbsr_pkg::op_t                 opcode,
    input  logic [rbsr_pkg::CNT_W-1:0]    request_count,
    input  logic                          capacity_we,
    input  logic [rbsr_pkg::CNT_W-1:0]    capacity,
    output logic                          done,
    output logic [rbsr_pkg::PTR_W-1:0]    first_offset,
    output logic [rbsr_pkg::CNT_W-1:0]    first_size,
    output logic [rbsr_pkg::PTR_W-1:0]    second_size,
    output logic [rbsr_pkg::CNT_W-1:0]    granted,
    output logic                          complete,
    output logic [rbsr_pkg::CNT_W-1:0]    fill_level
);
    import rbsr_pkg::*;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_BYTES);
    localparam logic [CNT_W-1:0] CAP_MIN = CNT_W'(1);

    logic             in_valid_reg;
    op_t              in_op_reg;
    logic [CNT_W-1:0] in_req_reg;

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    logic             done_reg;
    span_t            res_reg;

    span_t            span;

    assign busy = 1'b0;

    always_comb
    begin
        if (capacity == '0)
            cap_next = CAP_MIN;
        else if (capacity > CAP_MAX)
            cap_next = CAP_MAX;
        else
            cap_next = capacity;
    end

    rbsr_span_calc u_span (
        .op     (in_op_reg),
        .req    (in_req_reg),
        .cap    (cap_reg),
        .rd_ptr (rd_ptr_reg),
        .wr_ptr (wr_ptr_reg),
        .fill   (fill_reg),
        .span   (span)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            cap_reg      <= CAP_MAX;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
            if (capacity_we)
            begin
                // new capacity: drop all contents
                cap_reg    <= cap_next;
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
                fill_reg   <= '0;
            end
            else if (in_valid_reg)
            begin
                fill_reg <= span.next_fill;
                if (in_op_reg == OP_WRITE)
                    wr_ptr_reg <= span.next_ptr;
                else
                    rd_ptr_reg <= span.next_ptr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_op_reg  <= opcode;
            in_req_reg <= request_count;
        end
        if (in_valid_reg)
            res_reg <= span;
    end

    assign done         = done_reg;
    assign first_offset = res_reg.offset;
    assign first_size   = res_reg.first;
    assign second_size  = res_reg.second;
    assign granted      = res_reg.grant;
    assign complete     = res_reg.complete;
    assign fill_level   = res_reg.next_fill;

endmodule

// File: rtl/rbsr_checker.sv
// ----------------------------------------------------------------------------
// rbsr_checker
// Port-level checks of the ring buffer span reservation block, bound to the
// top level.
// ----------------------------------------------------------------------------
module rbsr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic [rbsr_pkg::PTR_W-1:0]    second_size,
    input  logic [rbsr_pkg::CNT_W-1:0]    first_size,
    input  logic [rbsr_pkg::CNT_W-1:0]    granted,
    input  logic                          complete
);
    import rbsr_pkg::*;

    logic [CNT_W:0] span_total;

    assign span_total = {1'b0, first_size} + {2'b00, second_size};

    // every accepted request yields its result, flagged by done
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request transfer without result");

    // no result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result transfer without request");

    a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, granted} <= span_total))
        else $error("grant exceeds reported regions");

    // a cut-down request takes all that is there
    a_partial_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !complete) |-> ({1'b0, granted} == span_total))
        else $error("partial grant below available space");

    a_wrap_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (first_size == '0)) |-> (second_size == '0))
        else $error("wrapped region without first region");

endmodule

bind ring_buffer_span_reservation rbsr_checker u_rbsr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .second_size (second_size),
    .first_size  (first_size),
    .granted     (granted),
    .complete    (complete)
);
